@@ sv/tsbt_pkg.sv @@
// shared types, constants and address helpers for the texture sampler core
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps

package tsbt_pkg;

    // texel store geometry: base level plus mip levels, back to back
    localparam int MAX_DIM     = 256;
    localparam int DIM_W       = 8;
    localparam int SIZE_W      = 9;
    localparam int MAX_LEVELS  = 8;
    localparam int LVL_W       = 4;
    localparam int CHAN_W      = 16;
    localparam int TEXEL_W     = 3 * CHAN_W;
    localparam int ADDR_W      = 17;
    localparam int STORE_DEPTH = 87381;

    // fixed-point formats
    localparam int COORD_W = 17;
    localparam int LOD_W   = 12;
    localparam int FRAC_W  = 9;
    localparam int PROD_W  = 26;
    localparam int WGT_W   = 17;

    // request payload layout on the slave tdata bus
    localparam int TDATA_W = 120;
    localparam int OUT_W   = 48;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        MODE_NEAREST   = 2'd0,
        MODE_BILINEAR  = 2'd1,
        MODE_TRILINEAR = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_LEVELS = 2'd3
    } t_reg;

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [TEXEL_W-1:0]         t_texel;
    typedef logic [3:0][ADDR_W-1:0]     t_quad;
    typedef logic [3:0][TEXEL_W-1:0]    t_tquad;

    // store write request, applied at the memory stage
    typedef struct packed {
        logic   we;
        t_addr  addr;
        t_texel data;
    } t_wr;

    // filter weights that travel alongside the texel reads
    typedef struct packed {
        logic              smp;
        logic [WGT_W-1:0]  s0;
        logic [WGT_W-1:0]  t0;
        logic [WGT_W-1:0]  s1;
        logic [WGT_W-1:0]  t1;
        logic [FRAC_W-1:0] f;
    } t_wgt;

    // first store entry of each level (sum of the squares above it)
    function automatic t_addr level_start(input logic [LVL_W-1:0] l);
        t_addr r;
        case (l)
            4'd0:    r = 17'd0;
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd81920;
            4'd3:    r = 17'd86016;
            4'd4:    r = 17'd87040;
            4'd5:    r = 17'd87296;
            4'd6:    r = 17'd87360;
            4'd7:    r = 17'd87376;
            4'd8:    r = 17'd87380;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/tsbt_texram.sv @@
// one bank of the texel store: one write port and two registered read ports
// depends on tsbt_pkg for widths, depth and the write request type
`timescale 1ns / 1ps

module tsbt_texram (
    input  logic               i_clk,
    input  logic               i_adv,
    input  tsbt_pkg::t_wr      i_wr,
    input  tsbt_pkg::t_addr    i_raddr_a,
    input  tsbt_pkg::t_addr    i_raddr_b,
    output tsbt_pkg::t_texel   o_rdata_a,
    output tsbt_pkg::t_texel   o_rdata_b
);

    tsbt_pkg::t_texel r_mem [0:tsbt_pkg::STORE_DEPTH-1];
    tsbt_pkg::t_texel r_rdata_a;
    tsbt_pkg::t_texel r_rdata_b;

    // write and read move together with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_wr.we) begin
                r_mem[i_wr.addr] <= i_wr.data;
            end
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ sv/tsbt_coord.sv @@
// front stages: request capture, level selection, coordinate scaling, texel addressing
// depends on tsbt_pkg; feeds the texel store banks and the filter stages
`timescale 1ns / 1ps

module tsbt_coord (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tsbt_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    input  logic                          i_op,
    input  logic [tsbt_pkg::TDATA_W-1:0]  i_data,
    output tsbt_pkg::t_wr                 o_wr,
    output tsbt_pkg::t_quad               o_addr0,
    output tsbt_pkg::t_quad               o_addr1,
    output tsbt_pkg::t_wgt                o_wgt
);

    typedef struct packed {
        logic [tsbt_pkg::DIM_W-1:0]  i0;
        logic [tsbt_pkg::DIM_W-1:0]  i1;
        logic [tsbt_pkg::WGT_W-1:0]  w;
    } t_axis;

    // level size max(1, eff >> l)
    function automatic logic [tsbt_pkg::SIZE_W-1:0] lvl_dim(
        input logic [tsbt_pkg::SIZE_W-1:0] eff,
        input logic [tsbt_pkg::LVL_W-1:0]  l
    );
        logic [tsbt_pkg::SIZE_W-1:0] d;
        d = eff >> l;
        return (d == '0) ? tsbt_pkg::SIZE_W'(1) : d;
    endfunction

    // store address of texel (x, y) in level l
    function automatic tsbt_pkg::t_addr addr_calc(
        input logic [tsbt_pkg::LVL_W-1:0] l,
        input logic [tsbt_pkg::DIM_W-1:0] x,
        input logic [tsbt_pkg::DIM_W-1:0] y
    );
        logic [tsbt_pkg::LVL_W-1:0] sh;
        sh = tsbt_pkg::LVL_W'(tsbt_pkg::DIM_W) - l;
        return tsbt_pkg::level_start(l) + (tsbt_pkg::ADDR_W'(y) << sh)
               + tsbt_pkg::ADDR_W'(x);
    endfunction

    // one axis: neighbor indexes and clamped weight, or the nearest index
    function automatic t_axis axis_calc(
        input logic [tsbt_pkg::PROD_W-1:0] x,
        input logic [tsbt_pkg::SIZE_W-1:0] n,
        input logic                        near
    );
        logic [tsbt_pkg::PROD_W-1:0] d;
        logic [tsbt_pkg::PROD_W-1:0] rel;
        logic [9:0]                  a;
        logic [9:0]                  nm1;
        logic [9:0]                  a1;
        t_axis                       r;
        nm1 = 10'(n) - 10'd1;
        d   = x - tsbt_pkg::PROD_W'(32768);
        a   = '0;
        r.w = '0;
        if (near) begin
            a = x[25:16];
        end else if (x >= tsbt_pkg::PROD_W'(32768)) begin
            a = d[25:16];
        end
        if (a > nm1) begin
            a = nm1;
        end
        rel = d - {a, 16'd0};
        if (!near && x >= tsbt_pkg::PROD_W'(32768)) begin
            r.w = (rel > tsbt_pkg::PROD_W'(65536)) ? 17'd65536 : rel[16:0];
        end
        a1 = (a + 10'd1 > nm1) ? nm1 : a + 10'd1;
        r.i0 = a[7:0];
        r.i1 = near ? a[7:0] : a1[7:0];
        return r;
    endfunction

    // configuration registers
    logic [1:0]                   r_mode;
    logic [tsbt_pkg::SIZE_W-1:0]  r_bw;
    logic [tsbt_pkg::SIZE_W-1:0]  r_bh;
    logic [tsbt_pkg::LVL_W-1:0]   r_lcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tsbt_pkg::MODE_BILINEAR;
            r_bw   <= 9'd256;
            r_bh   <= 9'd256;
            r_lcnt <= 4'd8;
        end else if (i_cfg_valid) begin
            unique case (tsbt_pkg::t_reg'(i_cfg_index))
                tsbt_pkg::REG_MODE:   r_mode <= i_cfg_data[1:0];
                tsbt_pkg::REG_WIDTH:  r_bw   <= i_cfg_data;
                tsbt_pkg::REG_HEIGHT: r_bh   <= i_cfg_data;
                tsbt_pkg::REG_LEVELS: r_lcnt <= i_cfg_data[3:0];
                default:              r_mode <= r_mode;
            endcase
        end
    end

    // stage 1: capture request, saturate coordinates
    logic                         r1_v;
    logic                         r1_op;
    logic [3:0]                   r1_lvl;
    logic [7:0]                   r1_wx;
    logic [7:0]                   r1_wy;
    tsbt_pkg::t_texel             r1_texel;
    logic [16:0]                  r1_u;
    logic [16:0]                  r1_cv;
    logic [11:0]                  r1_lod;
    logic [16:0]                  w_u_in;
    logic [16:0]                  w_v_in;

    assign w_u_in = i_data[84:68];
    assign w_v_in = i_data[101:85];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_op    <= i_op;
            r1_lvl   <= i_data[3:0];
            r1_wx    <= i_data[11:4];
            r1_wy    <= i_data[19:12];
            r1_texel <= i_data[67:20];
            r1_u     <= (w_u_in > 17'd65536) ? 17'd65536 : w_u_in;
            r1_cv    <= (w_v_in > 17'd65536) ? 17'd65536 : w_v_in;
            r1_lod   <= i_data[113:102];
        end
    end

    // stage 2: effective sizes, level pair and lod fraction, write address
    logic [8:0]  w_eff_w;
    logic [8:0]  w_eff_h;
    logic [3:0]  w_lc;
    logic [3:0]  w_l0;
    logic [3:0]  w_l1;
    logic [12:0] w_fr;
    logic [8:0]  w_f;
    logic        w_near;
    logic        w_tri;
    logic [8:0]  w_wdim;
    tsbt_pkg::t_wr n2_wr;

    always_comb begin
        w_eff_w = (r_bw == '0) ? 9'd1 : ((r_bw > 9'd256) ? 9'd256 : r_bw);
        w_eff_h = (r_bh == '0) ? 9'd1 : ((r_bh > 9'd256) ? 9'd256 : r_bh);
        w_lc    = (r_lcnt > 4'd8) ? 4'd8 : r_lcnt;
        w_near  = (r_mode == tsbt_pkg::MODE_NEAREST);
        w_tri   = !w_near && (r_mode != tsbt_pkg::MODE_BILINEAR);
        w_l0    = '0;
        w_l1    = '0;
        w_f     = '0;
        w_fr    = '0;
        if (w_tri) begin
            w_l0 = (r1_lod[11:8] > w_lc) ? w_lc : r1_lod[11:8];
            w_l1 = (w_l0 + 4'd1 > w_lc) ? w_lc : w_l0 + 4'd1;
            w_fr = 13'(r1_lod) - {1'b0, w_l0, 8'd0};
            w_f  = (w_fr > 13'd256) ? 9'd256 : w_fr[8:0];
        end
        // write path: ignore requests outside the store
        w_wdim        = 9'd256 >> r1_lvl;
        n2_wr.we      = r1_v && (r1_op == tsbt_pkg::OP_WRITE) && (r1_lvl <= 4'd8)
                        && ({1'b0, r1_wx} < w_wdim) && ({1'b0, r1_wy} < w_wdim);
        n2_wr.addr    = addr_calc(r1_lvl, r1_wx, r1_wy);
        n2_wr.data    = r1_texel;
    end

    logic          r2_smp;
    logic          r2_near;
    logic [3:0]    r2_l0;
    logic [3:0]    r2_l1;
    logic [8:0]    r2_f;
    logic [8:0]    r2_w0;
    logic [8:0]    r2_h0;
    logic [8:0]    r2_w1;
    logic [8:0]    r2_h1;
    logic [16:0]   r2_u;
    logic [16:0]   r2_cv;
    tsbt_pkg::t_wr r2_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_smp   <= 1'b0;
            r2_wr.we <= 1'b0;
        end else if (i_adv) begin
            r2_smp <= r1_v && (r1_op == tsbt_pkg::OP_SAMPLE);
            r2_wr  <= n2_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_near <= w_near;
            r2_l0   <= w_l0;
            r2_l1   <= w_l1;
            r2_f    <= w_f;
            r2_w0   <= lvl_dim(w_eff_w, w_l0);
            r2_h0   <= lvl_dim(w_eff_h, w_l0);
            r2_w1   <= lvl_dim(w_eff_w, w_l1);
            r2_h1   <= lvl_dim(w_eff_h, w_l1);
            r2_u    <= r1_u;
            r2_cv   <= r1_cv;
        end
    end

    // stage 3: scale coordinates by level sizes
    logic          r3_smp;
    logic          r3_near;
    logic [3:0]    r3_l0;
    logic [3:0]    r3_l1;
    logic [8:0]    r3_f;
    logic [8:0]    r3_w0;
    logic [8:0]    r3_h0;
    logic [8:0]    r3_w1;
    logic [8:0]    r3_h1;
    logic [25:0]   r3_px0;
    logic [25:0]   r3_py0;
    logic [25:0]   r3_px1;
    logic [25:0]   r3_py1;
    tsbt_pkg::t_wr r3_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_smp   <= 1'b0;
            r3_wr.we <= 1'b0;
        end else if (i_adv) begin
            r3_smp <= r2_smp;
            r3_wr  <= r2_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_near <= r2_near;
            r3_l0   <= r2_l0;
            r3_l1   <= r2_l1;
            r3_f    <= r2_f;
            r3_w0   <= r2_w0;
            r3_h0   <= r2_h0;
            r3_w1   <= r2_w1;
            r3_h1   <= r2_h1;
            r3_px0  <= 26'(r2_w0) * 26'(r2_u);
            r3_py0  <= 26'(r2_h0) * 26'(r2_cv);
            r3_px1  <= 26'(r2_w1) * 26'(r2_u);
            r3_py1  <= 26'(r2_h1) * 26'(r2_cv);
        end
    end

    // stage 4: neighbor indexes, weights and the eight read addresses
    t_axis w_ax0;
    t_axis w_ay0;
    t_axis w_ax1;
    t_axis w_ay1;

    assign w_ax0 = axis_calc(r3_px0, r3_w0, r3_near);
    assign w_ay0 = axis_calc(r3_py0, r3_h0, r3_near);
    assign w_ax1 = axis_calc(r3_px1, r3_w1, r3_near);
    assign w_ay1 = axis_calc(r3_py1, r3_h1, r3_near);

    tsbt_pkg::t_quad r4_addr0;
    tsbt_pkg::t_quad r4_addr1;
    tsbt_pkg::t_wgt  r4_wgt;
    tsbt_pkg::t_wr   r4_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_wgt.smp <= 1'b0;
            r4_wr.we   <= 1'b0;
        end else if (i_adv) begin
            r4_wgt.smp <= r3_smp;
            r4_wr      <= r3_wr;
            r4_wgt.s0  <= w_ax0.w;
            r4_wgt.t0  <= w_ay0.w;
            r4_wgt.s1  <= w_ax1.w;
            r4_wgt.t1  <= w_ay1.w;
            r4_wgt.f   <= r3_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_addr0[0] <= addr_calc(r3_l0, w_ax0.i0, w_ay0.i0);
            r4_addr0[1] <= addr_calc(r3_l0, w_ax0.i1, w_ay0.i0);
            r4_addr0[2] <= addr_calc(r3_l0, w_ax0.i0, w_ay0.i1);
            r4_addr0[3] <= addr_calc(r3_l0, w_ax0.i1, w_ay0.i1);
            r4_addr1[0] <= addr_calc(r3_l1, w_ax1.i0, w_ay1.i0);
            r4_addr1[1] <= addr_calc(r3_l1, w_ax1.i1, w_ay1.i0);
            r4_addr1[2] <= addr_calc(r3_l1, w_ax1.i0, w_ay1.i1);
            r4_addr1[3] <= addr_calc(r3_l1, w_ax1.i1, w_ay1.i1);
        end
    end

    assign o_wr    = r4_wr;
    assign o_addr0 = r4_addr0;
    assign o_addr1 = r4_addr1;
    assign o_wgt   = r4_wgt;

endmodule

@@ sv/tsbt_filter.sv @@
// back stages: horizontal lerp, vertical lerp with rounding, lod blend
// depends on tsbt_pkg; takes texels from the store banks and weights from tsbt_coord
`timescale 1ns / 1ps

module tsbt_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  tsbt_pkg::t_wgt              i_wgt,
    input  tsbt_pkg::t_tquad            i_tex0,
    input  tsbt_pkg::t_tquad            i_tex1,
    output logic                        o_valid,
    output logic [tsbt_pkg::OUT_W-1:0]  o_rgb
);

    // stage 5: weights aligned with the registered texel reads
    tsbt_pkg::t_wgt r5_wgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_wgt.smp <= 1'b0;
        end else if (i_adv) begin
            r5_wgt <= i_wgt;
        end
    end

    // one channel of one corner texel of either level
    function automatic logic [tsbt_pkg::CHAN_W-1:0] i_tex0_ch(
        input int lv,
        input int k,
        input int c
    );
        tsbt_pkg::t_texel t;
        t = (lv == 0) ? i_tex0[k] : i_tex1[k];
        return t[c*tsbt_pkg::CHAN_W +: tsbt_pkg::CHAN_W];
    endfunction

    // stage 6: horizontal blend of each row, per level and channel
    logic [31:0] n6_lo [0:1][0:2];
    logic [31:0] n6_hi [0:1][0:2];
    logic [31:0] r6_lo [0:1][0:2];
    logic [31:0] r6_hi [0:1][0:2];
    logic        r6_smp;
    logic [16:0] r6_t0;
    logic [16:0] r6_t1;
    logic [8:0]  r6_f;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n6_lo[0][c] = 32'(33'(i_tex0_ch(0, 0, c)) * 33'(17'd65536 - r5_wgt.s0)
                        + 33'(i_tex0_ch(0, 1, c)) * 33'(r5_wgt.s0));
            n6_hi[0][c] = 32'(33'(i_tex0_ch(0, 2, c)) * 33'(17'd65536 - r5_wgt.s0)
                        + 33'(i_tex0_ch(0, 3, c)) * 33'(r5_wgt.s0));
            n6_lo[1][c] = 32'(33'(i_tex0_ch(1, 0, c)) * 33'(17'd65536 - r5_wgt.s1)
                        + 33'(i_tex0_ch(1, 1, c)) * 33'(r5_wgt.s1));
            n6_hi[1][c] = 32'(33'(i_tex0_ch(1, 2, c)) * 33'(17'd65536 - r5_wgt.s1)
                        + 33'(i_tex0_ch(1, 3, c)) * 33'(r5_wgt.s1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_smp <= 1'b0;
        end else if (i_adv) begin
            r6_smp <= r5_wgt.smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_lo <= n6_lo;
            r6_hi <= n6_hi;
            r6_t0 <= r5_wgt.t0;
            r6_t1 <= r5_wgt.t1;
            r6_f  <= r5_wgt.f;
        end
    end

    // stage 7: vertical blend, round half up to texel units
    logic [48:0] n7_acc [0:1][0:2];
    logic [15:0] r7_smp_ch [0:1][0:2];
    logic        r7_smp;
    logic [8:0]  r7_f;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n7_acc[0][c] = 49'(r6_lo[0][c]) * 49'(17'd65536 - r6_t0)
                         + 49'(r6_hi[0][c]) * 49'(r6_t0) + (49'd1 << 31);
            n7_acc[1][c] = 49'(r6_lo[1][c]) * 49'(17'd65536 - r6_t1)
                         + 49'(r6_hi[1][c]) * 49'(r6_t1) + (49'd1 << 31);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_smp <= 1'b0;
        end else if (i_adv) begin
            r7_smp <= r6_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < 3; c++) begin
                r7_smp_ch[0][c] <= n7_acc[0][c][47:32];
                r7_smp_ch[1][c] <= n7_acc[1][c][47:32];
            end
            r7_f <= r6_f;
        end
    end

    // stage 8: blend the two levels by the lod fraction
    logic [24:0]               n8_acc [0:2];
    logic [tsbt_pkg::OUT_W-1:0] r8_rgb;
    logic                      r8_v;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n8_acc[c] = 25'(r7_smp_ch[0][c]) * 25'(9'd256 - r7_f)
                      + 25'(r7_smp_ch[1][c]) * 25'(r7_f) + 25'd128;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (i_adv) begin
            r8_v <= r7_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r8_rgb <= {n8_acc[2][23:8], n8_acc[1][23:8], n8_acc[0][23:8]};
        end
    end

    assign o_valid = r8_v;
    assign o_rgb   = r8_rgb;

endmodule

@@ sv/texture_sampler_bilinear_trilinear_core.sv @@
// texture sampler top level: coordinate stages, four store banks, filter, output queue
// depends on tsbt_pkg, tsbt_coord, tsbt_texram and tsbt_filter
// throughput: one request per cycle, writes and samples alike, while the queue has room
// pipeline: an accepted sample passes 8 pipeline stages and then the output queue before it
//   shows on o_m_tvalid; the texel store read is the fifth stage
// reset: synchronous active-low clears valid bits, queue and registers to their defaults;
//   the texel store is not cleared and holds no defined value until written
`timescale 1ns / 1ps

module texture_sampler_bilinear_trilinear_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tsbt_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // write_level, write_x, write_y, in_red, in_green, in_blue, coord_u, coord_v,
    // detail_level, zero fill
    input  logic [tsbt_pkg::TDATA_W-1:0]  i_s_tdata,
    // operation
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_red, out_green, out_blue
    output logic [tsbt_pkg::OUT_W-1:0]    o_m_tdata
);

    logic             w_adv;
    logic             w_push;
    logic             w_pop;
    tsbt_pkg::t_wr    w_wr;
    tsbt_pkg::t_quad  w_addr0;
    tsbt_pkg::t_quad  w_addr1;
    tsbt_pkg::t_wgt   w_wgt;
    tsbt_pkg::t_tquad w_tex0;
    tsbt_pkg::t_tquad w_tex1;
    logic             w_fvalid;
    logic [tsbt_pkg::OUT_W-1:0] w_frgb;

    // output queue state
    logic [tsbt_pkg::OUT_W-1:0] r_q [0:1];
    logic                       r_wp;
    logic                       r_rp;
    logic [1:0]                 r_cnt;

    // the pipeline moves whenever the queue has a free slot
    assign w_adv       = (r_cnt != 2'd2);
    assign o_s_tready  = w_adv;
    assign o_cfg_ready = 1'b1;

    tsbt_coord u_coord (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .i_op        (i_s_tuser),
        .i_data      (i_s_tdata),
        .o_wr        (w_wr),
        .o_addr0     (w_addr0),
        .o_addr1     (w_addr1),
        .o_wgt       (w_wgt)
    );

    // one bank per corner; port a serves the lower level, port b the upper
    for (genvar k = 0; k < 4; k++) begin : g_bank
        tsbt_texram u_bank (
            .i_clk     (i_clk),
            .i_adv     (w_adv),
            .i_wr      (w_wr),
            .i_raddr_a (w_addr0[k]),
            .i_raddr_b (w_addr1[k]),
            .o_rdata_a (w_tex0[k]),
            .o_rdata_b (w_tex1[k])
        );
    end

    tsbt_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_wgt   (w_wgt),
        .i_tex0  (w_tex0),
        .i_tex1  (w_tex1),
        .o_valid (w_fvalid),
        .o_rgb   (w_frgb)
    );

    // two-entry output queue decouples o_m_tready from the pipeline
    assign w_push = w_fvalid && w_adv;
    assign w_pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_frgb;
        end
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_q[r_rp];

    // queue never overfills
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_cnt != 2'd2))
        else $error("result pushed into full output queue");

    // a full queue holds the request side
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_s_tready)
        else $error("request accepted while output queue full");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending right after reset");

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the texture sampler core: stream requests in, filtered colors out
// depends on tsbt_pkg and the texture_sampler_bilinear_trilinear_core rtl
`timescale 1ns / 1ps

// color predictor and queue of expected colors
class texel_scoreboard;
    logic [47:0] store [tsbt_pkg::STORE_DEPTH];
    logic [47:0] pending_colors [$];
    int unsigned mode, base_w, base_h, levels;
    int unsigned errors;

    function new();
        mode = 1; base_w = 256; base_h = 256; levels = 8; errors = 0;
    endfunction

    function int unsigned dim_of(int unsigned l);
        int unsigned d;
        d = 256 >> l;
        return (d == 0) ? 1 : d;
    endfunction

    function int unsigned start_of(int unsigned l);
        int unsigned s;
        s = 0;
        for (int unsigned j = 0; j < l; j++) s += dim_of(j) * dim_of(j);
        return s;
    endfunction

    function int unsigned eff(int unsigned r);
        if (r == 0) return 1;
        return (r > 256) ? 256 : r;
    endfunction

    function int unsigned lsize(int unsigned base, int unsigned l);
        int unsigned d;
        d = eff(base) >> l;
        return (d == 0) ? 1 : d;
    endfunction

    // texel pair and weight along one axis, centers at half texel
    function void axis(int unsigned n, int unsigned c, output int unsigned i0,
                       output int unsigned i1, output longint unsigned w);
        longint unsigned x, a0, rel;
        x = longint'(n) * c;
        if (x < 32768) begin
            a0 = 0;
            w = 0;
        end else begin
            a0 = (x - 32768) >> 16;
            if (a0 > n - 1) a0 = n - 1;
            rel = x - 32768 - (a0 << 16);
            w = (rel > 65536) ? 65536 : rel;
        end
        i0 = 32'(a0);
        i1 = (a0 + 1 > n - 1) ? n - 1 : 32'(a0 + 1);
    endfunction

    function logic [47:0] bilin(int unsigned l, int unsigned u, int unsigned v);
        int unsigned x0, x1, y0, y1, st, dm;
        longint unsigned s, t, t00, t10, t01, t11, lo, hi, acc;
        logic [47:0] res;
        axis(lsize(base_w, l), u, x0, x1, s);
        axis(lsize(base_h, l), v, y0, y1, t);
        st = start_of(l);
        dm = dim_of(l);
        for (int c = 0; c < 3; c++) begin
            t00 = store[st + y0 * dm + x0][16*c +: 16];
            t10 = store[st + y0 * dm + x1][16*c +: 16];
            t01 = store[st + y1 * dm + x0][16*c +: 16];
            t11 = store[st + y1 * dm + x1][16*c +: 16];
            lo = t00 * (65536 - s) + t10 * s;
            hi = t01 * (65536 - s) + t11 * s;
            acc = lo * (65536 - t) + hi * t + (64'd1 << 31);
            res[16*c +: 16] = acc[47:32];
        end
        return res;
    endfunction

    function void set_reg(tsbt_pkg::t_reg idx, int unsigned val);
        case (idx)
            tsbt_pkg::REG_MODE:   mode = val & 3;
            tsbt_pkg::REG_WIDTH:  base_w = val & 9'h1ff;
            tsbt_pkg::REG_HEIGHT: base_h = val & 9'h1ff;
            default:              levels = val & 4'hf;
        endcase
    endfunction

    // accepted request: update the store or queue the expected color
    function void note_request(logic op, logic [119:0] d);
        int unsigned l, x, y, u, v, lod, lc, l0, l1, f, ix, iy;
        logic [47:0] res, s0, s1;
        longint unsigned acc;
        if (op == tsbt_pkg::OP_WRITE) begin
            l = d[3:0]; x = d[11:4]; y = d[19:12];
            if (l > 8) return;
            if (x >= dim_of(l) || y >= dim_of(l)) return;
            store[start_of(l) + y * dim_of(l) + x] = d[67:20];
            return;
        end
        u = d[84:68]; v = d[101:85]; lod = d[113:102];
        if (u > 65536) u = 65536;
        if (v > 65536) v = 65536;
        if (mode == tsbt_pkg::MODE_NEAREST) begin
            ix = 32'((longint'(eff(base_w)) * u) >> 16);
            iy = 32'((longint'(eff(base_h)) * v) >> 16);
            if (ix > eff(base_w) - 1) ix = eff(base_w) - 1;
            if (iy > eff(base_h) - 1) iy = eff(base_h) - 1;
            res = store[iy * 256 + ix];
        end else if (mode == tsbt_pkg::MODE_BILINEAR) begin
            res = bilin(0, u, v);
        end else begin
            lc = (levels > 8) ? 8 : levels;
            l0 = lod >> 8;
            if (l0 > lc) l0 = lc;
            l1 = (l0 + 1 > lc) ? lc : l0 + 1;
            f = (lod >= l0 * 256) ? lod - l0 * 256 : 0;
            if (f > 256) f = 256;
            s0 = bilin(l0, u, v);
            s1 = bilin(l1, u, v);
            for (int c = 0; c < 3; c++) begin
                acc = longint'(s0[16*c +: 16]) * (256 - f) + longint'(s1[16*c +: 16]) * f + 128;
                res[16*c +: 16] = acc[23:8];
            end
        end
        pending_colors.push_back(res);
    endfunction

    function void check_color(logic [47:0] act);
        logic [47:0] exp_c;
        if (pending_colors.size() == 0) begin
            $error("unexpected color %h", act);
            errors++;
            return;
        end
        exp_c = pending_colors.pop_front();
        if (act[15:0] !== exp_c[15:0]) begin
            $error("out_red expected %h actual %h", exp_c[15:0], act[15:0]);
            errors++;
        end
        if (act[31:16] !== exp_c[31:16]) begin
            $error("out_green expected %h actual %h", exp_c[31:16], act[31:16]);
            errors++;
        end
        if (act[47:32] !== exp_c[47:32]) begin
            $error("out_blue expected %h actual %h", exp_c[47:32], act[47:32]);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int STALL_LIMIT = 4000;
    // largest base size used by the bench; only this corner of each level is loaded
    localparam int FILL_DIM    = 16;

    logic         i_clk, i_rst_n;
    logic         i_cfg_valid, o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [8:0]   i_cfg_data;
    logic         i_s_tvalid, o_s_tready;
    logic [119:0] i_s_tdata;
    logic         i_s_tuser;
    logic         o_m_tvalid, i_m_tready;
    logic [47:0]  o_m_tdata;

    texel_scoreboard sb;
    bit calm;
    int unsigned stall_cycles;

    texture_sampler_bilinear_trilinear_core DUT (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_s_tvalid = 0; i_s_tdata = 0; i_s_tuser = 0; i_m_tready = 0;
        calm = 1;
        sb = new();
    end

    // result side: random back-pressure, check every accepted color
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_color(o_m_tdata);
        i_m_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("texture_sampler_bilinear_trilinear_core verification failed");
            $finish;
        end
    end

    // loaded extent of level l
    function automatic int unsigned fill_dim(int unsigned l);
        int unsigned d;
        d = FILL_DIM >> l;
        return (d == 0) ? 1 : d;
    endfunction

    function automatic logic [119:0] pack_req(int unsigned l, int unsigned x, int unsigned y,
            logic [47:0] rgb, int unsigned u, int unsigned v, int unsigned lod);
        logic [119:0] d;
        d = '0;
        d[3:0] = 4'(l); d[11:4] = 8'(x); d[19:12] = 8'(y); d[67:20] = rgb;
        d[84:68] = 17'(u); d[101:85] = 17'(v); d[113:102] = 12'(lod);
        return d;
    endfunction

    function automatic logic [47:0] rand_rgb();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic send_request(logic op, logic [119:0] d);
        while (!calm && $urandom_range(0, 99) < 20) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= op;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, d);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        do @(posedge i_clk); while (sb.pending_colors.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(tsbt_pkg::t_reg idx, int unsigned val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= 9'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned m, int unsigned w, int unsigned h, int unsigned lc);
        drain();
        write_reg(tsbt_pkg::REG_MODE, m);
        write_reg(tsbt_pkg::REG_WIDTH, w);
        write_reg(tsbt_pkg::REG_HEIGHT, h);
        write_reg(tsbt_pkg::REG_LEVELS, lc);
    endtask

    task automatic sample(int unsigned u, int unsigned v, int unsigned lod);
        send_request(tsbt_pkg::OP_SAMPLE, pack_req($urandom_range(0, 15),
                     $urandom_range(0, 255), $urandom_range(0, 255), rand_rgb(), u, v, lod));
    endtask

    // mix of texel overwrites, stray writes and samples
    task automatic random_items(int n);
        int unsigned k, u, v, l;
        for (int i = 0; i < n; i++) begin
            if (i == 60) calm = 0;
            k = $urandom_range(0, 99);
            if (k < 25) begin
                l = $urandom_range(0, 8);
                send_request(tsbt_pkg::OP_WRITE, pack_req(l,
                             $urandom_range(0, sb.dim_of(l) - 1),
                             $urandom_range(0, sb.dim_of(l) - 1), rand_rgb(), $urandom,
                             $urandom, $urandom));
            end else if (k < 32) begin
                send_request(tsbt_pkg::OP_WRITE, pack_req($urandom_range(0, 15),
                             $urandom_range(0, 255), $urandom_range(0, 255), rand_rgb(),
                             $urandom, $urandom, $urandom));
            end else begin
                u = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                                 : $urandom_range(0, 65536);
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                                 : $urandom_range(0, 65536);
                sample(u, v, $urandom_range(0, 4095));
            end
            if (i == n / 2 && $urandom_range(0, 1)) begin
                i_s_tvalid <= 0;
                do @(posedge i_clk); while (sb.pending_colors.size() != 0);
            end
        end
    endtask

    initial begin
        #0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // load the corner of every level that the bench sizes can reach
        for (int l = 0; l <= 8; l++)
            for (int y = 0; y < fill_dim(l); y++)
                for (int x = 0; x < fill_dim(l); x++)
                    send_request(tsbt_pkg::OP_WRITE, pack_req(l, x, y, rand_rgb(), 0, 0, 0));

        // directed: coordinate and lod extremes, stray writes, each mode
        send_request(tsbt_pkg::OP_WRITE, pack_req(9, 0, 0, 48'hffff_ffff_ffff, 0, 0, 0));
        send_request(tsbt_pkg::OP_WRITE, pack_req(15, 255, 255, 48'h0, 0, 0, 0));
        send_request(tsbt_pkg::OP_WRITE, pack_req(1, 128, 3, rand_rgb(), 0, 0, 0));
        send_request(tsbt_pkg::OP_WRITE, pack_req(8, 0, 1, rand_rgb(), 0, 0, 0));
        send_request(tsbt_pkg::OP_WRITE, pack_req(0, 255, 255, 48'hffff_ffff_ffff, 0, 0, 0));
        send_request(tsbt_pkg::OP_WRITE, pack_req(0, 0, 0, 48'h0, 0, 0, 0));
        set_config(tsbt_pkg::MODE_BILINEAR, FILL_DIM, FILL_DIM, 8);
        sample(0, 0, 0);
        sample(65536, 65536, 4095);
        sample(131071, 131071, 0);
        sample(128, 65535, 0);
        set_config(tsbt_pkg::MODE_NEAREST, FILL_DIM, FILL_DIM, 8);
        sample(0, 0, 0);
        sample(65536, 65536, 0);
        sample(131071, 32768, 0);
        set_config(tsbt_pkg::MODE_TRILINEAR, FILL_DIM, FILL_DIM, 8);
        sample(32768, 32768, 0);
        sample(32768, 32768, 384);
        sample(32768, 32768, 2048);
        sample(65536, 0, 4095);
        set_config(3, 0, FILL_DIM, 15);
        sample(40000, 50000, 1000);
        sample(65536, 65536, 4095);
        set_config(2, 1, 1, 0);
        sample(65536, 131071, 300);
        sample(0, 0, 4095);

        // random phases across settings, extremes first
        calm = 1;
        set_config(tsbt_pkg::MODE_BILINEAR, FILL_DIM, FILL_DIM, 8);
        random_items(250);
        calm = 1;
        set_config(tsbt_pkg::MODE_NEAREST, 1, FILL_DIM, 0);
        random_items(200);
        calm = 1;
        set_config(tsbt_pkg::MODE_TRILINEAR, FILL_DIM, 1, 15);
        random_items(200);
        calm = 1;
        set_config(3, FILL_DIM, 0, 3);
        random_items(200);
        for (int p = 0; p < 5; p++) begin
            calm = 1;
            set_config($urandom_range(0, 3), $urandom_range(0, FILL_DIM),
                       $urandom_range(0, FILL_DIM), $urandom_range(0, 15));
            random_items(110);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.pending_colors.size() != 0) begin
            $error("%0d expected colors never arrived", sb.pending_colors.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("texture_sampler_bilinear_trilinear_core verification clean");
        else
            $display("texture_sampler_bilinear_trilinear_core verification failed");
        $finish;
    end
endmodule
